// ----- rtl/length_framed_packet_receiver_macros.svh -----
// assertion helpers used by the checker file
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LFPR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfpr check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define LFPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfpr check failed");

`endif

// ----- rtl/lfpr_pkg.sv -----
package lfpr_pkg;

	localparam int DEF_FRAME_SLOTS = 4;
	localparam int DEF_FRAME_BYTES = 64;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 2 * BYTE_W;
	localparam int HDR_MARGIN = 3;

	localparam logic [BYTE_W-1:0] START_CHAR = 8'h24;
	localparam logic [BYTE_W-1:0] END_CHAR   = 8'h40;

	// one result as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              is_frame_byte;
		logic              last;
		logic              queue_empty;
		logic              frame_done;
		logic              frame_dropped;
	} result_t;

endpackage

// ----- rtl/lfpr_ram.sv -----
module lfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lfpr_parser.sv -----
module lfpr_parser
	import lfpr_pkg::*;
#(
	parameter int FRAME_SLOTS = DEF_FRAME_SLOTS,
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               take,
	input  logic [BYTE_W-1:0]                                  rx_byte,
	input  logic                                               ring_full,
	output logic                                               fwe,
	output logic [$clog2(FRAME_SLOTS)+$clog2(FRAME_BYTES)-1:0] fwaddr,
	output logic [BYTE_W-1:0]                                  fwdata,
	output logic                                               lwe,
	output logic [$clog2(FRAME_SLOTS)-1:0]                     lwaddr,
	output logic [$clog2(FRAME_BYTES+1)-1:0]                   lwdata,
	output logic                                               res_vld,
	output result_t                                            res
);

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int OFS_W  = $clog2(FRAME_BYTES);
	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

	typedef enum logic [5:0] {
		PS_HEAD0 = 6'b000001,
		PS_HEAD1 = 6'b000010,
		PS_LENH  = 6'b000100,
		PS_LENL  = 6'b001000,
		PS_DAT   = 6'b010000,
		PS_TAIL  = 6'b100000
	} pstate_t;

	pstate_t            state_q;
	logic [LEN_W-1:0]   exp_q;
	logic [CNT_W-1:0]   wc_q;
	logic [SLOT_W-1:0]  wslot_q;
	logic               blocked_q;

	logic [CNT_W-1:0]   wc_inc;
	logic [LEN_W-1:0]   wc_ext;
	logic [LEN_W-1:0]   len_full;
	logic               hdr_ok;
	logic               store;
	logic               tail_end;
	logic               dropped;
	logic               done;

	assign wc_inc   = wc_q + 1'b1;
	assign wc_ext   = LEN_W'(wc_inc);
	assign len_full = {exp_q[LEN_W-1:BYTE_W], rx_byte};
	assign hdr_ok   = ({1'b0, len_full} + (LEN_W+1)'(HDR_MARGIN)) < (LEN_W+1)'(FRAME_BYTES);

	assign store = take && (state_q == PS_LENH || state_q == PS_LENL || state_q == PS_DAT);

	// a frame that began on a full ring is parsed but never written
	assign fwe    = store && !blocked_q && (wc_q < CNT_W'(FRAME_BYTES));
	assign fwaddr = {wslot_q, wc_q[OFS_W-1:0]};
	assign fwdata = rx_byte;

	assign tail_end = take && (state_q == PS_TAIL) && (rx_byte == END_CHAR);
	assign dropped  = tail_end && (blocked_q || ring_full);
	assign done     = tail_end && !dropped;

	assign lwe    = done;
	assign lwaddr = wslot_q;
	assign lwdata = wc_q;

	assign res_vld = take;
	always_comb begin
		res               = '0;
		res.last          = 1'b1;
		res.frame_done    = done;
		res.frame_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= PS_HEAD0;
			exp_q     <= '0;
			wc_q      <= '0;
			wslot_q   <= '0;
			blocked_q <= 1'b0;
		end else if (take) begin
			unique case (state_q)
				PS_HEAD0: begin
					if (rx_byte == START_CHAR) begin
						state_q <= PS_HEAD1;
					end
					wc_q <= '0;
				end
				PS_HEAD1: begin
					if (rx_byte == START_CHAR) begin
						state_q   <= PS_LENH;
						wc_q      <= '0;
						blocked_q <= ring_full;
					end else begin
						state_q <= PS_HEAD0;
					end
				end
				PS_LENH: begin
					wc_q    <= wc_inc;
					exp_q   <= {rx_byte, {BYTE_W{1'b0}}};
					state_q <= PS_LENL;
				end
				PS_LENL: begin
					wc_q    <= wc_inc;
					exp_q   <= len_full;
					state_q <= hdr_ok ? PS_DAT : PS_HEAD0;
				end
				PS_DAT: begin
					wc_q <= wc_inc;
					if (wc_ext == exp_q) begin
						state_q <= PS_TAIL;
					end else if (wc_ext > exp_q) begin
						state_q <= PS_HEAD0;
					end
				end
				PS_TAIL: begin
					if (done) begin
						wslot_q <= (wslot_q == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : wslot_q + 1'b1;
					end
					state_q <= PS_HEAD0;
				end
				default: begin
					state_q <= PS_HEAD0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/lfpr_popper.sv -----
module lfpr_popper
	import lfpr_pkg::*;
#(
	parameter int FRAME_SLOTS = DEF_FRAME_SLOTS,
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               take,
	input  logic                                               ring_empty,
	output logic                                               busy,
	output logic                                               lre,
	output logic [$clog2(FRAME_SLOTS)-1:0]                     lraddr,
	input  logic [$clog2(FRAME_BYTES+1)-1:0]                   lrdata,
	output logic                                               fre,
	output logic [$clog2(FRAME_SLOTS)+$clog2(FRAME_BYTES)-1:0] fraddr,
	input  logic [BYTE_W-1:0]                                  frdata,
	output logic                                               res_vld,
	output result_t                                            res,
	output logic                                               slot_freed
);

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int OFS_W  = $clog2(FRAME_BYTES);
	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

	typedef enum logic [2:0] {
		QS_IDLE   = 3'b001,
		QS_LEN    = 3'b010,
		QS_STREAM = 3'b100
	} qstate_t;

	qstate_t           state_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              is_last;
	logic [OFS_W-1:0]  rofs;

	assign busy    = (state_q != QS_IDLE);
	assign is_last = (cnt_q == len_q);

	assign lre    = take && !ring_empty;
	assign lraddr = rslot_q;

	// cnt_q runs one ahead of the byte whose data is on frdata
	assign rofs   = (state_q == QS_STREAM) ? cnt_q[OFS_W-1:0] : '0;
	assign fraddr = {rslot_q, rofs};
	assign fre    = (state_q == QS_LEN) || ((state_q == QS_STREAM) && !is_last);

	assign slot_freed = (state_q == QS_STREAM) && is_last;

	always_comb begin
		res     = '0;
		res_vld = 1'b0;
		if (state_q == QS_STREAM) begin
			res_vld           = 1'b1;
			res.data_byte     = frdata;
			res.is_frame_byte = 1'b1;
			res.last          = is_last;
		end else if (take && ring_empty) begin
			res_vld         = 1'b1;
			res.queue_empty = 1'b1;
			res.last        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= QS_IDLE;
			rslot_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				QS_IDLE: begin
					if (take && !ring_empty) begin
						state_q <= QS_LEN;
					end
				end
				QS_LEN: begin
					len_q   <= lrdata;
					cnt_q   <= CNT_W'(1);
					state_q <= QS_STREAM;
				end
				QS_STREAM: begin
					cnt_q <= cnt_q + 1'b1;
					if (is_last) begin
						rslot_q <= (rslot_q == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : rslot_q + 1'b1;
						state_q <= QS_IDLE;
					end
				end
				default: begin
					state_q <= QS_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/length_framed_packet_receiver.sv -----
// channel  | direction | handshake                  | fields
// ---------+-----------+----------------------------+-------------------------------------------
// request  | in        | start high while busy low  | cmd, rx_byte
// result   | out       | strobe high for one cycle  | data_byte, is_frame_byte, last,
//          |           |                            | queue_empty, frame_done, frame_dropped
//
// a parse request's single result shows in the next cycle and a new request may follow
// right away
// a pop of an empty ring answers in the next cycle; a pop of an n-byte frame keeps busy
// high after the request until its last byte leaves the popper, paced by one slot-length
// read and then one frame-RAM read per byte, and its bytes pass through the output register
// arst_n clears all control state; the frame and length RAMs are not cleared
// the receiver cannot stall: results leave through a plain output register
module length_framed_packet_receiver
	import lfpr_pkg::*;
#(
	parameter int FRAME_SLOTS = DEF_FRAME_SLOTS,
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              strobe,
	output logic [BYTE_W-1:0] data_byte,
	output logic              is_frame_byte,
	output logic              last,
	output logic              queue_empty,
	output logic              frame_done,
	output logic              frame_dropped
);

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int OFS_W  = $clog2(FRAME_BYTES);
	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
	localparam int HELD_W = $clog2(FRAME_SLOTS + 1);
	localparam int ADDR_W = SLOT_W + OFS_W;

	// frame RAM: each slot owns a power-of-two window, slot number in the upper bits
	localparam int STORE_DEPTH = FRAME_SLOTS * (2 ** OFS_W);

	logic              accept;
	logic              parse_take;
	logic              pop_take;

	// count of complete frames in the ring
	logic [HELD_W-1:0] held_q;
	logic              ring_full;
	logic              ring_empty;

	logic              fwe;
	logic [ADDR_W-1:0] fwaddr;
	logic [BYTE_W-1:0] fwdata;
	logic              fre;
	logic [ADDR_W-1:0] fraddr;
	logic [BYTE_W-1:0] frdata;

	logic              lwe;
	logic [SLOT_W-1:0] lwaddr;
	logic [CNT_W-1:0]  lwdata;
	logic              lre;
	logic [SLOT_W-1:0] lraddr;
	logic [CNT_W-1:0]  lrdata;

	logic              p_vld;
	result_t           p_res;
	logic              q_vld;
	result_t           q_res;
	logic              slot_freed;

	logic              strobe_q;
	result_t           res_q;

	// busy only covers a pop in flight, so parse writes and pop reads of the RAMs never
	// share a cycle; a length written at a tail byte is in the RAM before any later pop
	// can read it
	assign accept     = start && !busy;
	assign parse_take = accept && !cmd;
	assign pop_take   = accept && cmd;

	assign ring_full  = (held_q == HELD_W'(FRAME_SLOTS));
	assign ring_empty = (held_q == '0);

	lfpr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (fwe),
		.waddr (fwaddr),
		.wdata (fwdata),
		.re    (fre),
		.raddr (fraddr),
		.rdata (frdata)
	);

	lfpr_ram #(
		.WIDTH (CNT_W),
		.DEPTH (FRAME_SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (lre),
		.raddr (lraddr),
		.rdata (lrdata)
	);

	lfpr_parser #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (parse_take),
		.rx_byte   (rx_byte),
		.ring_full (ring_full),
		.fwe       (fwe),
		.fwaddr    (fwaddr),
		.fwdata    (fwdata),
		.lwe       (lwe),
		.lwaddr    (lwaddr),
		.lwdata    (lwdata),
		.res_vld   (p_vld),
		.res       (p_res)
	);

	lfpr_popper #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_popper (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (pop_take),
		.ring_empty (ring_empty),
		.busy       (busy),
		.lre        (lre),
		.lraddr     (lraddr),
		.lrdata     (lrdata),
		.fre        (fre),
		.fraddr     (fraddr),
		.frdata     (frdata),
		.res_vld    (q_vld),
		.res        (q_res),
		.slot_freed (slot_freed)
	);

	// a stored frame and a freed slot never meet in one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (p_vld && p_res.frame_done) begin
			held_q <= held_q + 1'b1;
		end else if (slot_freed) begin
			held_q <= held_q - 1'b1;
		end
	end

	// output register; parser and popper results are never valid together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= p_vld || q_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (p_vld) begin
			res_q <= p_res;
		end else if (q_vld) begin
			res_q <= q_res;
		end
	end

	assign strobe        = strobe_q;
	assign data_byte     = res_q.data_byte;
	assign is_frame_byte = res_q.is_frame_byte;
	assign last          = res_q.last;
	assign queue_empty   = res_q.queue_empty;
	assign frame_done    = res_q.frame_done;
	assign frame_dropped = res_q.frame_dropped;

endmodule

// ----- rtl/lfpr_checker.sv -----
`include "length_framed_packet_receiver_macros.svh"

module lfpr_checker
	import lfpr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              cmd,
	input logic [BYTE_W-1:0] rx_byte,
	input logic              strobe,
	input logic [BYTE_W-1:0] data_byte,
	input logic              is_frame_byte,
	input logic              last,
	input logic              queue_empty,
	input logic              frame_done,
	input logic              frame_dropped
);

	// a parse request answers in the very next cycle
	`LFPR_ASSERT_NEXT(a_parse_answers, start && !busy && !cmd, strobe)
	// a pop either answers at once or holds the block busy
	`LFPR_ASSERT_NEXT(a_pop_answers, start && !busy && cmd, strobe || busy)
	// busy falls exactly with the last popped byte
	`LFPR_ASSERT_SAME(a_pop_busy, strobe && is_frame_byte, busy == !last)
	// an empty-ring answer carries nothing else
	`LFPR_ASSERT_SAME(a_empty_clean, strobe && queue_empty,
		last && !is_frame_byte && !frame_done && !frame_dropped && (data_byte == '0))

endmodule

bind length_framed_packet_receiver lfpr_checker u_lfpr_checker (.*);
